// ----- rtl/core/phm_pkg.sv -----
// Package: shared constants, types and state codes of the pitch histogram mode block.
package phm_pkg;

    localparam int BINS         = 150;
    localparam int COUNT_W      = 16;
    localparam int BIN_W        = (BINS > 1) ? $clog2(BINS) : 1;
    localparam int PITCH_W      = 12;
    localparam int CONF_W       = 16;
    localparam int FRAC_W       = 16;
    localparam int MODE_PITCH_W = 8;
    localparam int TOTAL_W      = 16;
    localparam int SHARE_W      = 17;
    localparam int NUM_W        = COUNT_W + FRAC_W;
    localparam int STEP_W       = $clog2(NUM_W + 1);

    localparam logic [CONF_W-1:0] THRESH_RESET = CONF_W'(19660);

    typedef logic [BIN_W-1:0]   bin_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic [2:0] {
        ST_RUN,
        ST_DRAIN,
        ST_SCAN,
        ST_LAST,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the sequencer to the histogram store
    typedef struct packed {
        logic upd;
        logic scan;
        logic clear;
        bin_t addr;
    } hist_cmd_t;

endpackage

// ----- rtl/core/phm_ifs.sv -----
// Interfaces: frame request channel and result request channel.
interface phm_frame_if;
    logic                           valid;
    logic                           ready;
    logic [phm_pkg::PITCH_W-1:0]    pitch_whole;
    logic [phm_pkg::CONF_W-1:0]     confidence;
    logic                           last_frame;

    modport source (output valid, output pitch_whole, output confidence,
                    output last_frame, input ready);
    modport sink (input valid, input pitch_whole, input confidence,
                  input last_frame, output ready);
endinterface

interface phm_result_if;
    logic                               valid;
    logic                               ready;
    logic [phm_pkg::MODE_PITCH_W-1:0]   mode_pitch;
    logic [phm_pkg::COUNT_W-1:0]        mode_count;
    logic [phm_pkg::TOTAL_W-1:0]        accepted_total;
    logic [phm_pkg::SHARE_W-1:0]        mode_share;

    modport source (output valid, output mode_pitch, output mode_count,
                    output accepted_total, output mode_share, input ready);
    modport sink (input valid, input mode_pitch, input mode_count,
                  input accepted_total, input mode_share, output ready);
endinterface

// ----- rtl/core/pitch_histogram_mode_core.sv -----
// Top level: pitch histogram mode finder with frame and result request channels.
//
// Frames arrive on the frame channel (valid/ready). A frame whose pitch lies in
// 1..BINS-1 and whose confidence is strictly above the threshold adds one to its
// pitch bin and to the total. Ordinary frames are taken one per cycle; a bin
// update is a read-modify-write on the bin memory with one-deep forwarding.
// A frame marked last_frame ends the note: ready drops while the block drains
// the update stage, scans all BINS bins through the memory read port, then runs
// the bit-serial divider for the share (32 quotient bits, one a cycle) and moves
// the result to the output register once that is free. The scan over the single
// read port and the divider make up most of that work.
// The result stays in the output register until the receiver takes it; frames
// of the next note are taken meanwhile, but the next note's result waits, with
// ready low, for the slot to free. The histogram is cleared at the end of the
// scan.
// Reset clears the histogram, the total, all handshakes, and sets the
// threshold to 19660 (about 0.3 in Q0.16). cfg_we writes the threshold.
module pitch_histogram_mode_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [phm_pkg::CONF_W-1:0]      cfg_wdata,
    phm_frame_if.sink                       frame,
    phm_result_if.source                    result
);

    localparam int BINS    = phm_pkg::BINS;
    localparam int BIN_W   = phm_pkg::BIN_W;
    localparam int PITCH_W = phm_pkg::PITCH_W;
    localparam int MP_W    = phm_pkg::MODE_PITCH_W;
    localparam int TOTAL_W = phm_pkg::TOTAL_W;
    localparam int SHARE_W = phm_pkg::SHARE_W;

    localparam logic [PITCH_W:0] PITCH_LIM = (PITCH_W + 1)'(BINS);
    localparam logic [BIN_W-1:0] LAST_BIN  = BIN_W'(BINS - 1);

    phm_pkg::state_t state_reg;
    phm_pkg::state_t state_next;

    logic [phm_pkg::CONF_W-1:0] thresh_reg;

    // Sequencer outputs
    phm_pkg::hist_cmd_t cmd;
    logic               div_start;
    logic               res_load;

    logic accept;
    logic hit;

    phm_pkg::count_t scan_data;
    phm_pkg::count_t acc_count;

    // Scan: address issue and compare of the data in the cycle after
    phm_pkg::bin_t   scan_addr_reg;
    logic            cmp_vld_reg;
    phm_pkg::bin_t   cmp_idx_reg;
    phm_pkg::bin_t   best_idx_reg;
    phm_pkg::count_t best_cnt_reg;
    phm_pkg::bin_t   best_idx_next;
    phm_pkg::count_t best_cnt_next;

    // Held note result while the share is computed
    phm_pkg::bin_t   hold_idx_reg;
    phm_pkg::count_t hold_cnt_reg;
    phm_pkg::count_t hold_tot_reg;

    logic               div_done;
    logic [SHARE_W-1:0] div_quot;

    // Output register
    logic                  out_vld_reg;
    logic [MP_W-1:0]       out_pitch_reg;
    phm_pkg::count_t       out_cnt_reg;
    logic [TOTAL_W-1:0]    out_tot_reg;
    logic [SHARE_W-1:0]    out_share_reg;

    assign accept = frame.valid && frame.ready;
    assign hit    = (frame.pitch_whole != '0)
                 && ({1'b0, frame.pitch_whole} < PITCH_LIM)
                 && (frame.confidence > thresh_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            phm_pkg::ST_RUN:
            begin
                if (accept && frame.last_frame)
                begin
                    state_next = phm_pkg::ST_DRAIN;
                end
            end
            phm_pkg::ST_DRAIN:
            begin
                state_next = phm_pkg::ST_SCAN;
            end
            phm_pkg::ST_SCAN:
            begin
                if (scan_addr_reg == LAST_BIN)
                begin
                    state_next = phm_pkg::ST_LAST;
                end
            end
            phm_pkg::ST_LAST:
            begin
                state_next = phm_pkg::ST_DIV;
            end
            phm_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = phm_pkg::ST_OUT;
                end
            end
            phm_pkg::ST_OUT:
            begin
                if (!out_vld_reg || result.ready)
                begin
                    state_next = phm_pkg::ST_RUN;
                end
            end
            default:
            begin
                state_next = phm_pkg::ST_RUN;
            end
        endcase
    end

    // Sequencer outputs
    always_comb
    begin
        frame.ready = 1'b0;
        cmd.upd     = 1'b0;
        cmd.scan    = 1'b0;
        cmd.clear   = 1'b0;
        cmd.addr    = scan_addr_reg;
        div_start   = 1'b0;
        res_load    = 1'b0;
        unique case (state_reg)
            phm_pkg::ST_RUN:
            begin
                frame.ready = 1'b1;
                cmd.upd     = frame.valid && hit;
                cmd.addr    = BIN_W'(frame.pitch_whole);
            end
            phm_pkg::ST_SCAN:
            begin
                cmd.scan = 1'b1;
            end
            phm_pkg::ST_LAST:
            begin
                cmd.clear = 1'b1;
                div_start = 1'b1;
            end
            phm_pkg::ST_OUT:
            begin
                res_load = !out_vld_reg || result.ready;
            end
            default:
            begin
                frame.ready = 1'b0;
            end
        endcase
    end

    // First maximum wins: replace only on a strictly larger count
    always_comb
    begin
        best_idx_next = best_idx_reg;
        best_cnt_next = best_cnt_reg;
        if (cmp_vld_reg && (scan_data > best_cnt_reg))
        begin
            best_idx_next = cmp_idx_reg;
            best_cnt_next = scan_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= phm_pkg::ST_RUN;
            thresh_reg    <= phm_pkg::THRESH_RESET;
            scan_addr_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_idx_reg   <= '0;
            best_idx_reg  <= '0;
            best_cnt_reg  <= '0;
            out_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                thresh_reg <= cfg_wdata;
            end

            cmp_vld_reg <= cmd.scan;
            cmp_idx_reg <= scan_addr_reg;
            if (state_reg == phm_pkg::ST_DRAIN)
            begin
                // Restart the scan from bin 0 with an empty best
                scan_addr_reg <= '0;
                best_idx_reg  <= '0;
                best_cnt_reg  <= '0;
            end
            else
            begin
                if (cmd.scan)
                begin
                    scan_addr_reg <= scan_addr_reg + 1'b1;
                end
                best_idx_reg <= best_idx_next;
                best_cnt_reg <= best_cnt_next;
            end

            if (res_load)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            hold_idx_reg <= best_idx_next;
            hold_cnt_reg <= best_cnt_next;
            hold_tot_reg <= acc_count;
        end
        if (res_load)
        begin
            out_pitch_reg <= MP_W'(hold_idx_reg);
            out_cnt_reg   <= hold_cnt_reg;
            out_tot_reg   <= TOTAL_W'(hold_tot_reg);
            out_share_reg <= div_quot;
        end
    end

    phm_hist u_hist (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .scan_data (scan_data),
        .acc_count (acc_count)
    );

    phm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (best_cnt_next),
        .den   (acc_count),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign result.valid          = out_vld_reg;
    assign result.mode_pitch     = out_pitch_reg;
    assign result.mode_count     = out_cnt_reg;
    assign result.accepted_total = out_tot_reg;
    assign result.mode_share     = out_share_reg;

    // A last frame closes the note: no frame is taken in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame.last_frame) |=> !frame.ready)
        else $error("frame taken right after last frame");

    // A result only appears after its note's share is done
    assert property (@(posedge clk) disable iff (!rst_n)
        res_load |-> div_done)
        else $error("result loaded before division finished");

endmodule

// ----- rtl/core/phm_hist.sv -----
// Histogram store: bin memory with read-modify-write, forwarding and scan read.
module phm_hist (
    input  logic                clk,
    input  logic                rst_n,
    input  phm_pkg::hist_cmd_t  cmd,
    output phm_pkg::count_t     scan_data,
    output phm_pkg::count_t     acc_count
);

    localparam int BINS    = phm_pkg::BINS;
    localparam int COUNT_W = phm_pkg::COUNT_W;

    logic [COUNT_W-1:0] mem [BINS];
    logic [BINS-1:0]    bin_vld_reg;

    phm_pkg::count_t rd_data_reg;
    logic            rd_vld_reg;
    logic            upd_reg;
    phm_pkg::bin_t   upd_addr_reg;
    logic            wr_en_reg;
    phm_pkg::bin_t   wr_addr_reg;
    phm_pkg::count_t wr_data_reg;
    phm_pkg::count_t acc_reg;
    phm_pkg::count_t acc_next;

    phm_pkg::count_t cur_val;
    phm_pkg::count_t new_val;
    logic            rd_en;

    assign rd_en = cmd.upd || cmd.scan;

    // Synchronous read port, registered in rd_data_reg
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[cmd.addr];
        end
    end

    // Write port: increment result of the update stage
    always_ff @(posedge clk)
    begin
        if (upd_reg)
        begin
            mem[upd_addr_reg] <= new_val;
        end
    end

    always_comb
    begin
        // Take the previous write when it hit the same bin: the read missed it
        if (wr_en_reg && (wr_addr_reg == upd_addr_reg))
        begin
            cur_val = wr_data_reg;
        end
        else if (rd_vld_reg)
        begin
            cur_val = rd_data_reg;
        end
        else
        begin
            cur_val = '0;
        end
        new_val  = (cur_val == '1) ? cur_val : cur_val + 1'b1;
        acc_next = (acc_reg == '1) ? acc_reg : acc_reg + 1'b1;
    end

    assign scan_data = rd_vld_reg ? rd_data_reg : '0;
    assign acc_count = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_vld_reg  <= '0;
            rd_vld_reg   <= 1'b0;
            upd_reg      <= 1'b0;
            upd_addr_reg <= '0;
            wr_en_reg    <= 1'b0;
            wr_addr_reg  <= '0;
            wr_data_reg  <= '0;
            acc_reg      <= '0;
        end
        else
        begin
            if (rd_en)
            begin
                rd_vld_reg <= bin_vld_reg[cmd.addr];
            end
            upd_reg      <= cmd.upd;
            upd_addr_reg <= cmd.addr;
            wr_en_reg    <= upd_reg;
            wr_addr_reg  <= upd_addr_reg;
            wr_data_reg  <= new_val;
            if (cmd.clear)
            begin
                bin_vld_reg <= '0;
                acc_reg     <= '0;
                wr_en_reg   <= 1'b0;
            end
            else if (upd_reg)
            begin
                bin_vld_reg[upd_addr_reg] <= 1'b1;
                acc_reg                   <= acc_next;
            end
        end
    end

    // A bin never exceeds the total of counted frames
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> (wr_data_reg <= acc_reg))
        else $error("bin count above accepted total");

    // Forwarded write always belongs to the previous update
    assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> $past(upd_reg))
        else $error("write register without preceding update");

endmodule

// ----- rtl/core/phm_div.sv -----
// Divider: restoring bit-serial division of count<<16 by total, one bit a cycle.
module phm_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  phm_pkg::count_t                 num,
    input  phm_pkg::count_t                 den,
    output logic                            done,
    output logic [phm_pkg::SHARE_W-1:0]     quot
);

    localparam int COUNT_W = phm_pkg::COUNT_W;
    localparam int FRAC_W  = phm_pkg::FRAC_W;
    localparam int NUM_W   = phm_pkg::NUM_W;
    localparam int STEP_W  = phm_pkg::STEP_W;
    localparam int SHARE_W = phm_pkg::SHARE_W;

    logic [NUM_W-1:0]   num_reg;
    logic [COUNT_W-1:0] rem_reg;
    logic [COUNT_W-1:0] den_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               busy_reg;
    logic               done_reg;
    logic               zero_reg;

    logic [COUNT_W:0]   rem_sh;
    logic [COUNT_W:0]   diff;
    logic               ge;

    always_comb
    begin
        rem_sh = {rem_reg, num_reg[NUM_W-1]};
        diff   = rem_sh - {1'b0, den_reg};
        ge     = (rem_sh >= {1'b0, den_reg});
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {num, {FRAC_W{1'b0}}};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], ge};
            rem_reg <= ge ? diff[COUNT_W-1:0] : rem_sh[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            zero_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            zero_reg <= (den == '0);
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quot = zero_reg ? '0 : num_reg[SHARE_W-1:0];

    assert property (@(posedge clk) disable iff (!rst_n)
        start |=> (busy_reg && !done_reg))
        else $error("divider did not start");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> (step_reg == '0))
        else $error("divider finished early");

endmodule
